// ----- hw/rtl/snx_pkg.sv -----
// Shared constants, tables and helper functions for the 2D simplex noise pipeline.
// Depends on nothing; every module of the block imports it.
package snx_pkg;

    localparam int IN_FRAC_BITS_DEF = 16;
    localparam int OUT_BITS_DEF     = 16;

    // Skew and unskew factors, unsigned Q0.32.
    localparam logic [31:0] F2_Q32 = 32'd1572067139;
    localparam logic [31:0] G2_Q32 = 32'd907633386;

    // Corner offsets are carried in Q.32 over OFS_W bits, then in Q.28 over 32 bits.
    localparam int OFS_BITS = 28;
    localparam int OFS_W    = 36;
    localparam logic [OFS_W-1:0] ONE_Q32  = OFS_W'(64'd1 << 32);
    localparam logic [OFS_W-1:0] OFF2_Q32 = OFS_W'(64'd2 * 64'(G2_Q32)) - ONE_Q32;
    localparam int CONTRIB_W = 35;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [3:0]         g;
    } corner_t;

    localparam logic [7:0] PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

    // Remainder by twelve through a reciprocal multiply; exact for all 8-bit values.
    function automatic logic [3:0] mod12(input logic [7:0] h);
        logic [15:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 16'(h) * 16'd171;
        q = 8'(p[15:11]);
        r = h - q * 8'd12;
        return r[3:0];
    endfunction

    // Dot product with the edge gradient picked by the index g, from 0 through 11.
    function automatic logic signed [33:0] grad_dot(input logic [3:0] g,
                                                    input logic signed [31:0] x,
                                                    input logic signed [31:0] y);
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic signed [33:0] gx;
        logic signed [33:0] gy;
        xs = 34'(x);
        ys = 34'(y);
        case (g) inside
            4'd0, 4'd2, 4'd4, 4'd6: gx = xs;
            4'd1, 4'd3, 4'd5, 4'd7: gx = -xs;
            default:                gx = '0;
        endcase
        case (g) inside
            4'd0, 4'd1, 4'd8, 4'd10: gy = ys;
            4'd2, 4'd3, 4'd9, 4'd11: gy = -ys;
            default:                 gy = '0;
        endcase
        return gx + gy;
    endfunction

endpackage

// ----- hw/rtl/simplex_noise_2d.sv -----
// Two-dimensional simplex noise: one point in, one noise value out, through a
// 14-stage pipeline that takes a new point in every clock cycle when the output
// is not held off. Six stages skew the point, find the cell and hash its
// corners, five more evaluate each corner on its own multipliers, and three sum,
// scale and saturate; each variable multiplier is at most 34 by 33
// bits. A stall on the output side freezes the whole pipeline, so no point is
// lost or repeated.
// Depends on snx_pkg, snx_cell, snx_corner and snx_sum.
module simplex_noise_2d
    import snx_pkg::*;
#(
    parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF,
    parameter int OUT_BITS     = OUT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,  // point_x, point_y
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((OUT_BITS + 7) / 8) * 8 - 1:0] m_tdata  // noise_value
);
    localparam int OW = ((OUT_BITS + 7) / 8) * 8;

    logic                        en;
    logic                        cell_valid;
    corner_t                     corners [3];
    logic [4:0]                  cvld_reg;
    logic signed [CONTRIB_W-1:0] contrib [3];
    logic signed [OUT_BITS-1:0]  value;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    snx_cell #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_cell (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_x       ($signed(s_tdata[31:0])),
        .in_y       ($signed(s_tdata[63:32])),
        .out_valid  (cell_valid),
        .out_corner (corners)
    );

    for (genvar k = 0; k < 3; k++) begin : g_corner
        snx_corner u_corner (
            .aclk      (aclk),
            .en        (en),
            .in_corner (corners[k]),
            .contrib   (contrib[k])
        );
    end

    // Valid bits that keep step with the corner stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvld_reg <= '0;
        end else if (en) begin
            cvld_reg <= {cvld_reg[3:0], cell_valid};
        end
    end

    snx_sum #(
        .OUT_BITS(OUT_BITS)
    ) u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cvld_reg[4]),
        .c0        (contrib[0]),
        .c1        (contrib[1]),
        .c2        (contrib[2]),
        .out_valid (m_tvalid),
        .out_value (value)
    );

    assign m_tdata = OW'($unsigned(value));

endmodule

// ----- hw/rtl/snx_cell.sv -----
// Front end of the noise pipeline: skew, cell floor, unskew, triangle pick and hashing.
// Six register stages; uses snx_pkg for constants and the permutation table.
module snx_cell
    import snx_pkg::*;
#(
    parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [31:0]  in_x,
    input  logic signed [31:0]  in_y,
    output logic                out_valid,
    output corner_t             out_corner [3]
);
    localparam int PXW = 64 - IN_FRAC_BITS;
    localparam int CW  = 33 - IN_FRAC_BITS;
    localparam int TW  = CW + 33;
    localparam int WW  = 68 - IN_FRAC_BITS;
    localparam int NST = 6;

    logic [NST-1:0]        vld_reg;
    logic signed [31:0]    x_reg    [4];
    logic signed [31:0]    y_reg    [4];
    logic signed [32:0]    v_reg;
    logic signed [63:0]    prod_reg;
    logic signed [CW-1:0]  ci_reg   [2];
    logic signed [CW-1:0]  cj_reg   [2];
    logic signed [TW-1:0]  t_reg;
    logic [7:0]            pj0_reg;
    logic [7:0]            pj1_reg;
    logic signed [OFS_W-1:0] x0_reg;
    logic signed [OFS_W-1:0] y0_reg;
    logic [7:0]            h0_reg;
    logic [7:0]            hx_reg;
    logic [7:0]            hy_reg;
    logic [7:0]            h2_reg;
    corner_t               crn_reg  [3];

    logic signed [63:0]    vf2;
    logic signed [PXW-1:0] px3, py3, s3;
    logic signed [PXW:0]   ax3, ay3;
    logic signed [CW:0]    csum4;
    logic signed [TW-1:0]  t4;
    logic [7:0]            cj4;
    logic signed [PXW-1:0] px5, py5;
    logic signed [WW-1:0]  x0w5, y0w5;
    logic [7:0]            ci5;
    logic                  i1_6;
    logic signed [OFS_W-1:0] x1_6, y1_6, x2_6, y2_6;

    always_comb begin
        vf2   = v_reg * $signed({1'b0, F2_Q32});
        px3   = {x_reg[1], (32 - IN_FRAC_BITS)'(0)};
        py3   = {y_reg[1], (32 - IN_FRAC_BITS)'(0)};
        s3    = PXW'(prod_reg >>> IN_FRAC_BITS);
        ax3   = (PXW+1)'(px3) + (PXW+1)'(s3);
        ay3   = (PXW+1)'(py3) + (PXW+1)'(s3);
        csum4 = (CW+1)'(ci_reg[0]) + (CW+1)'(cj_reg[0]);
        t4    = csum4 * $signed({1'b0, G2_Q32});
        cj4   = cj_reg[0][7:0];
        px5   = {x_reg[3], (32 - IN_FRAC_BITS)'(0)};
        py5   = {y_reg[3], (32 - IN_FRAC_BITS)'(0)};
        x0w5  = WW'(px5) - WW'($signed({ci_reg[1], 32'd0})) + WW'(t_reg);
        y0w5  = WW'(py5) - WW'($signed({cj_reg[1], 32'd0})) + WW'(t_reg);
        ci5   = ci_reg[1][7:0];
        // Equal offsets fall to the upper triangle.
        i1_6  = x0_reg > y0_reg;
        x1_6  = x0_reg - (i1_6 ? ONE_Q32 : '0) + OFS_W'(G2_Q32);
        y1_6  = y0_reg - (i1_6 ? '0 : ONE_Q32) + OFS_W'(G2_Q32);
        x2_6  = x0_reg + OFF2_Q32;
        y2_6  = y0_reg + OFF2_Q32;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]  <= in_x;
            y_reg[0]  <= in_y;
            v_reg     <= 33'(in_x) + 33'(in_y);
            for (int k = 1; k < 4; k++) begin
                x_reg[k] <= x_reg[k-1];
                y_reg[k] <= y_reg[k-1];
            end
            prod_reg  <= vf2;
            ci_reg[0] <= ax3[PXW:32];
            cj_reg[0] <= ay3[PXW:32];
            ci_reg[1] <= ci_reg[0];
            cj_reg[1] <= cj_reg[0];
            t_reg     <= t4;
            pj0_reg   <= PERM[cj4];
            pj1_reg   <= PERM[8'(cj4 + 8'd1)];
            x0_reg    <= x0w5[OFS_W-1:0];
            y0_reg    <= y0w5[OFS_W-1:0];
            h0_reg    <= PERM[8'(ci5 + pj0_reg)];
            hx_reg    <= PERM[8'(ci5 + 8'd1 + pj0_reg)];
            hy_reg    <= PERM[8'(ci5 + pj1_reg)];
            h2_reg    <= PERM[8'(ci5 + 8'd1 + pj1_reg)];
            crn_reg[0] <= '{x: x0_reg[OFS_W-1:4], y: y0_reg[OFS_W-1:4], g: mod12(h0_reg)};
            crn_reg[1] <= '{x: x1_6[OFS_W-1:4], y: y1_6[OFS_W-1:4],
                            g: mod12(i1_6 ? hx_reg : hy_reg)};
            crn_reg[2] <= '{x: x2_6[OFS_W-1:4], y: y2_6[OFS_W-1:4], g: mod12(h2_reg)};
        end
    end

    assign out_valid  = vld_reg[NST-1];
    assign out_corner = crn_reg;

endmodule

// ----- hw/rtl/snx_corner.sv -----
// Contribution of one simplex corner: attenuation, its fourth power and the gradient product.
// Five register stages; uses snx_pkg for the corner type and gradient function.
module snx_corner
    import snx_pkg::*;
(
    input  logic                        aclk,
    input  logic                        en,
    input  corner_t                     in_corner,
    output logic signed [CONTRIB_W-1:0] contrib
);
    logic [35:0]                sqx_reg, sqy_reg;
    logic signed [33:0]         d_reg [4];
    logic [2:0]                 neg_reg;
    logic [27:0]                att_reg;
    logic [27:0]                a2_reg;
    logic [27:0]                a4_reg;
    logic signed [CONTRIB_W-1:0] contrib_reg;

    logic signed [63:0] xx, yy;
    logic signed [37:0] att;
    logic [55:0]        att_sq, a2_sq;
    logic signed [62:0] prod;

    always_comb begin
        xx     = in_corner.x * in_corner.x;
        yy     = in_corner.y * in_corner.y;
        att    = 38'(64'd1 << (OFS_BITS - 1)) - 38'(sqx_reg) - 38'(sqy_reg);
        att_sq = 56'(att_reg) * 56'(att_reg);
        a2_sq  = 56'(a2_reg) * 56'(a2_reg);
        prod   = $signed({1'b0, a4_reg}) * d_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg  <= xx[63:28];
            sqy_reg  <= yy[63:28];
            d_reg[0] <= grad_dot(in_corner.g, in_corner.x, in_corner.y);
            for (int k = 1; k < 4; k++) begin
                d_reg[k] <= d_reg[k-1];
            end
            neg_reg  <= {neg_reg[1:0], att[37]};
            att_reg  <= att[27:0];
            a2_reg   <= att_sq[55:28];
            a4_reg   <= a2_sq[55:28];
            // A corner out of reach adds nothing.
            contrib_reg <= neg_reg[2] ? '0 : prod[62:28];
        end
    end

    assign contrib = contrib_reg;

endmodule

// ----- hw/rtl/snx_sum.sv -----
// Sum of the three corner contributions, scaling by 70, rounding and saturation.
// Three register stages ending in the output register; uses snx_pkg.
module snx_sum
    import snx_pkg::*;
#(
    parameter int OUT_BITS = OUT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [CONTRIB_W-1:0] c0,
    input  logic signed [CONTRIB_W-1:0] c1,
    input  logic signed [CONTRIB_W-1:0] c2,
    output logic                        out_valid,
    output logic signed [OUT_BITS-1:0]  out_value
);
    localparam int SH = OFS_BITS - (OUT_BITS - 1);
    localparam int SW = CONTRIB_W + 2;
    localparam int MW = SW + 8;
    localparam logic signed [MW-1:0] LIM = MW'((64'd1 << (OUT_BITS - 1)) - 64'd1);

    logic [2:0]                 vld_reg;
    logic signed [SW-1:0]       sum_reg;
    logic signed [MW-1:0]       rnd_reg;
    logic signed [OUT_BITS-1:0] out_reg;

    logic signed [MW-1:0] scaled, shifted;
    logic signed [OUT_BITS-1:0] sat;

    always_comb begin
        scaled  = MW'(sum_reg) * MW'(70) + MW'(64'd1 << (SH - 1));
        shifted = rnd_reg >>> SH;
        if (shifted > LIM) begin
            sat = OUT_BITS'(LIM);
        end else if (shifted < -LIM) begin
            sat = OUT_BITS'(-LIM);
        end else begin
            sat = shifted[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= SW'(c0) + SW'(c1) + SW'(c2);
            rnd_reg <= scaled;
            out_reg <= sat;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_value = out_reg;

endmodule
